@@ rtl/sasi_pkg.sv @@
// Shared types, codes and constants of the shape area sorted insert core.
package sasi_pkg;

    localparam int AREA_W   = 30;
    localparam int DP_W     = 64;
    localparam int MUL_W    = 32;
    localparam int M_DATA_W = ((AREA_W + 7) / 8) * 8;
    localparam int M_USER_W = 4;

    localparam logic [DP_W-1:0] PI_NUM  = 64'd314159;
    localparam logic [DP_W-1:0] PI_DEN  = 64'd100000;
    localparam logic [DP_W-1:0] PI_HALF = 64'd50000;

    // pi * 256 / 100000 per unit of r squared = 804 + 772 / 3125
    localparam logic [MUL_W-1:0] CIRC_INT   = 32'd804;
    localparam logic [MUL_W-1:0] CIRC_FRAC  = 32'd772;
    localparam logic [DP_W-1:0]  CIRC_ROUND = 64'd1562;
    localparam logic [DP_W-1:0]  CIRC_DIV   = 64'd3125;
    // floor(2^43 / 3125), applied to the numerator without its two low bits
    localparam logic [MUL_W-1:0] CIRC_RECIP = 32'd2814749767;
    localparam int               CIRC_SHIFT = 41;

    typedef enum logic [1:0] {
        KIND_RECT,
        KIND_CIRC,
        KIND_TRI,
        KIND_UNKNOWN
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [AREA_W-1:0] area;
        logic              bad;
    } entry_t;

    typedef struct packed {
        logic   start;
        logic   last;
        entry_t entry;
    } ins_req_t;

    typedef struct packed {
        entry_t entry;
        logic   dropped;
        logic   run_end;
    } out_item_t;

    function automatic logic [AREA_W-1:0] sat_area(input logic [DP_W-1:0] v);
        logic [DP_W-1:0] lim;
        lim = {{(DP_W-AREA_W){1'b0}}, {AREA_W{1'b1}}};
        if (v > lim) begin
            return {AREA_W{1'b1}};
        end
        return v[AREA_W-1:0];
    endfunction

endpackage

@@ rtl/sasi_area.sv @@
// Iterative area unit: one shared multiplier and one shared subtractor under a sequencer.
module sasi_area #(
    parameter int SIDE_BITS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  sasi_pkg::kind_t        kind_in,
    input  logic [SIDE_BITS-1:0]   side_a,
    input  logic [SIDE_BITS-1:0]   side_b,
    input  logic [SIDE_BITS-1:0]   side_c,
    output logic                   done,
    output sasi_pkg::entry_t       res
);

    localparam int DW    = sasi_pkg::DP_W;
    localparam int MW    = sasi_pkg::MUL_W;
    localparam int SW    = SIDE_BITS + 2;

    typedef enum logic [3:0] {
        A_IDLE, A_RECT, A_CIR1, A_CIR2, A_CIR3, A_CIR4, A_CIR5, A_CIR6, A_FIX, A_QSAT,
        A_TRI1, A_TRI2, A_TRI3, A_SQRT, A_RND
    } astate_t;

    astate_t          state_reg;
    logic [MW-1:0]    op_s_reg, op_f1_reg, op_f2_reg, op_f3_reg;
    logic [DW-1:0]    acc_reg, rem_reg, root_reg, bit_reg;
    logic [6:0]       cnt_reg;
    logic             done_reg;
    sasi_pkg::entry_t res_reg;

    logic [SIDE_BITS:0] sum_bc, sum_ac, sum_ab;
    logic [SW-1:0]      perim;
    logic               tri_bad;
    logic [MW-1:0]      mul_a, mul_b;
    logic [2*MW-1:0]    mul_p;
    logic [DW-1:0]      sub_a, sub_b;
    logic [DW:0]        diff;
    logic               borrow;

    assign sum_bc  = {1'b0, side_b} + {1'b0, side_c};
    assign sum_ac  = {1'b0, side_a} + {1'b0, side_c};
    assign sum_ab  = {1'b0, side_a} + {1'b0, side_b};
    assign perim   = SW'(side_a) + SW'(side_b) + SW'(side_c);
    assign tri_bad = ({1'b0, side_a} > sum_bc) || ({1'b0, side_b} > sum_ac) ||
                     ({1'b0, side_c} > sum_ab);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            A_RECT: begin mul_a = op_s_reg; mul_b = op_f1_reg; end
            A_CIR1: begin mul_a = op_s_reg; mul_b = op_s_reg; end
            A_CIR2: begin mul_a = acc_reg[MW-1:0]; mul_b = sasi_pkg::CIRC_INT; end
            A_CIR3: begin mul_a = acc_reg[MW-1:0]; mul_b = sasi_pkg::CIRC_FRAC; end
            A_CIR4: begin mul_a = rem_reg[MW+1:2]; mul_b = sasi_pkg::CIRC_RECIP; end
            A_CIR5: begin mul_a = acc_reg[MW-1:0]; mul_b = sasi_pkg::CIRC_DIV[MW-1:0]; end
            A_TRI1: begin mul_a = op_s_reg; mul_b = op_f1_reg; end
            A_TRI2: begin mul_a = op_f2_reg; mul_b = op_f3_reg; end
            A_TRI3: begin mul_a = acc_reg[MW-1:0]; mul_b = root_reg[MW-1:0]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            A_CIR6:  begin sub_a = rem_reg; sub_b = bit_reg; end
            A_FIX:   begin sub_a = rem_reg; sub_b = sasi_pkg::CIRC_DIV; end
            A_SQRT:  begin sub_a = rem_reg; sub_b = root_reg + bit_reg; end
            default: begin sub_a = '0; sub_b = '0; end
        endcase
    end

    assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = diff[DW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE: begin
                    if (start) begin
                        res_reg.kind <= kind_in;
                        res_reg.bad  <= 1'b0;
                        op_s_reg     <= MW'(side_a);
                        op_f1_reg    <= MW'(side_b);
                        unique case (kind_in)
                            sasi_pkg::KIND_RECT: state_reg <= A_RECT;
                            sasi_pkg::KIND_CIRC: state_reg <= A_CIR1;
                            sasi_pkg::KIND_TRI: begin
                                op_s_reg  <= MW'(perim);
                                op_f1_reg <= MW'(sum_bc - {1'b0, side_a});
                                op_f2_reg <= MW'(sum_ac - {1'b0, side_b});
                                op_f3_reg <= MW'(sum_ab - {1'b0, side_c});
                                if (tri_bad) begin
                                    res_reg.bad  <= 1'b1;
                                    res_reg.area <= '0;
                                    done_reg     <= 1'b1;
                                end else begin
                                    state_reg <= A_TRI1;
                                end
                            end
                            sasi_pkg::KIND_UNKNOWN: begin
                                // unknown kind: a circle of radius zero
                                res_reg.kind <= sasi_pkg::KIND_CIRC;
                                res_reg.area <= '0;
                                done_reg     <= 1'b1;
                            end
                            default: state_reg <= A_IDLE;
                        endcase
                    end
                end
                A_RECT: begin
                    res_reg.area <= sasi_pkg::sat_area(DW'(mul_p) << 8);
                    done_reg     <= 1'b1;
                    state_reg    <= A_IDLE;
                end
                A_CIR1: begin
                    acc_reg   <= DW'(mul_p);
                    state_reg <= A_CIR2;
                end
                A_CIR2: begin
                    // whole part of the area
                    root_reg  <= DW'(mul_p);
                    state_reg <= A_CIR3;
                end
                A_CIR3: begin
                    // rounded numerator of the fraction over 3125
                    rem_reg   <= DW'(mul_p) + sasi_pkg::CIRC_ROUND;
                    state_reg <= A_CIR4;
                end
                A_CIR4: begin
                    // quotient estimate, at most one short
                    acc_reg   <= DW'(mul_p >> sasi_pkg::CIRC_SHIFT);
                    state_reg <= A_CIR5;
                end
                A_CIR5: begin
                    bit_reg   <= DW'(mul_p);
                    state_reg <= A_CIR6;
                end
                A_CIR6: begin
                    rem_reg   <= diff[DW-1:0];
                    state_reg <= A_FIX;
                end
                A_FIX: begin
                    if (!borrow) begin
                        acc_reg <= acc_reg + 64'd1;
                    end
                    state_reg <= A_QSAT;
                end
                A_QSAT: begin
                    res_reg.area <= sasi_pkg::sat_area(root_reg + acc_reg);
                    done_reg     <= 1'b1;
                    state_reg    <= A_IDLE;
                end
                A_TRI1: begin
                    acc_reg   <= DW'(mul_p);
                    state_reg <= A_TRI2;
                end
                A_TRI2: begin
                    root_reg  <= DW'(mul_p);
                    state_reg <= A_TRI3;
                end
                A_TRI3: begin
                    rem_reg   <= DW'(mul_p) << 12;
                    root_reg  <= '0;
                    bit_reg   <= {{(DW-1){1'b0}}, 1'b1} << (DW - 2);
                    cnt_reg   <= 7'(DW / 2);
                    state_reg <= A_SQRT;
                end
                A_SQRT: begin
                    if (!borrow) begin
                        rem_reg  <= diff[DW-1:0];
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1) begin
                        state_reg <= A_RND;
                    end
                end
                A_RND: begin
                    // round to nearest from the remainder
                    if (rem_reg > root_reg) begin
                        res_reg.area <= sasi_pkg::sat_area(root_reg + 64'd1);
                    end else begin
                        res_reg.area <= sasi_pkg::sat_area(root_reg);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ rtl/sasi_table.sv @@
// Sorted table: memory, binary search, entry shifting and ordered readout.
module sasi_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sasi_pkg::ins_req_t    req,
    output logic                  done,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sasi_pkg::out_item_t   out_item
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [3:0] {
        T_IDLE, T_SRCH, T_CMP, T_SHR, T_SHW, T_RD, T_RW, T_OUT, T_FIN
    } tstate_t;

    tstate_t             state_reg;
    logic [CW-1:0]       count_reg, head_reg, tail_reg, idx_reg;
    logic                ovf_reg, last_reg, out_valid_reg;
    sasi_pkg::entry_t    new_reg, rd_data_reg;
    sasi_pkg::out_item_t out_reg;
    sasi_pkg::entry_t    mem [TABLE_DEPTH];

    logic [CW:0]         mid_sum;
    logic [CW-1:0]       mid, idx_m1;
    logic                we;
    logic [AW-1:0]       wa, ra;
    sasi_pkg::entry_t    wd;

    assign mid_sum = {1'b0, head_reg} + {1'b0, tail_reg};
    assign mid     = mid_sum[CW:1];
    assign idx_m1  = idx_reg - {{(CW-1){1'b0}}, 1'b1};

    always_comb begin
        we = 1'b0;
        wa = idx_reg[AW-1:0];
        wd = rd_data_reg;
        ra = mid[AW-1:0];
        case (state_reg)
            T_SHR: begin
                if (idx_reg == tail_reg) begin
                    we = 1'b1;
                    wd = new_reg;
                end else begin
                    ra = idx_m1[AW-1:0];
                end
            end
            T_SHW:   we = 1'b1;
            T_RD:    ra = idx_reg[AW-1:0];
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                T_IDLE: begin
                    if (req.start) begin
                        new_reg  <= req.entry;
                        last_reg <= req.last;
                        head_reg <= '0;
                        tail_reg <= count_reg;
                        idx_reg  <= '0;
                        if (count_reg == CW'(TABLE_DEPTH)) begin
                            // table full: drop the shape
                            ovf_reg   <= 1'b1;
                            state_reg <= req.last ? T_RD : T_FIN;
                        end else begin
                            state_reg <= T_SRCH;
                        end
                    end
                end
                T_SRCH: begin
                    if (head_reg < tail_reg) begin
                        state_reg <= T_CMP;
                    end else begin
                        idx_reg   <= count_reg;
                        state_reg <= T_SHR;
                    end
                end
                T_CMP: begin
                    // equal areas go after existing entries
                    if (new_reg.area < rd_data_reg.area) begin
                        tail_reg <= mid;
                    end else begin
                        head_reg <= mid + {{(CW-1){1'b0}}, 1'b1};
                    end
                    state_reg <= T_SRCH;
                end
                T_SHR: begin
                    if (idx_reg == tail_reg) begin
                        count_reg <= count_reg + {{(CW-1){1'b0}}, 1'b1};
                        idx_reg   <= '0;
                        state_reg <= last_reg ? T_RD : T_FIN;
                    end else begin
                        state_reg <= T_SHW;
                    end
                end
                T_SHW: begin
                    idx_reg   <= idx_m1;
                    state_reg <= T_SHR;
                end
                T_RD: state_reg <= T_RW;
                T_RW: begin
                    out_reg.entry   <= rd_data_reg;
                    out_reg.dropped <= ovf_reg;
                    out_reg.run_end <= (({1'b0, idx_reg} + {{CW{1'b0}}, 1'b1}) ==
                                        {1'b0, count_reg});
                    out_valid_reg   <= 1'b1;
                    state_reg       <= T_OUT;
                end
                T_OUT: begin
                    if (out_ready) begin
                        out_valid_reg <= 1'b0;
                        if (out_reg.run_end) begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= T_FIN;
                        end else begin
                            idx_reg   <= idx_reg + {{(CW-1){1'b0}}, 1'b1};
                            state_reg <= T_RD;
                        end
                    end
                end
                T_FIN: state_reg <= T_IDLE;
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign done      = (state_reg == T_FIN);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");
    a_valid_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> state_reg == T_OUT)
        else $error("result shown outside readout");
    a_run_end_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_ready && out_reg.run_end) |=> count_reg == '0 && !ovf_reg)
        else $error("table not emptied after readout");
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_IDLE && req.start && count_reg == CW'(TABLE_DEPTH)) |=> ovf_reg)
        else $error("drop not flagged");
`endif

endmodule

@@ rtl/shape_area_sorted_insert_core.sv @@
// Top level of the shape area sorted insert core.
// Usage:
//   Input stream s_*: one shape per transfer. s_tuser carries the kind, s_tdata
//   the three sides, s_tlast marks the final shape of a batch.
//   Output stream m_*: on the marked shape the table is sent in ascending area
//   order, one entry per transfer, m_tlast on the final entry.
// Timing:
//   s_tready is high only while the block is idle; a shape is then taken in,
//   its area is worked out and it is inserted before the next one is accepted.
//   The area time is set by the shared multiplier, the reciprocal divide by a
//   constant and the one-bit-a-cycle square root. The insertion time grows with
//   each binary search probe and each entry moved up, set by the single memory
//   port pair.
//   Readout reads, registers and shows each entry in turn as the receiver takes it.
// Reset: aresetn (synchronous, active low) empties the table and clears the
//   drop flag; no clearing pass is needed.
// Stall: a result waits in the output register while m_tready is low, and
//   the block accepts nothing until the readout has finished.
module shape_area_sorted_insert_core #(
    parameter int TABLE_DEPTH = 32,
    parameter int SIDE_BITS   = 10,
    localparam int S_DATA_W   = ((3 * SIDE_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_DATA_W-1:0]           s_tdata,  // side_first, side_second, side_third
    input  logic [1:0]                    s_tuser,  // shape_kind
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sasi_pkg::M_DATA_W-1:0] m_tdata,  // area_q8
    output logic [sasi_pkg::M_USER_W-1:0] m_tuser,  // kind_out, bad_triangle, dropped_any
    output logic                          m_tlast
);

    typedef enum logic [1:0] {S_IDLE, S_START, S_AREA, S_TAB} sstate_t;

    sstate_t                state_reg;
    sasi_pkg::kind_t        kind_reg;
    logic [SIDE_BITS-1:0]   a_reg, b_reg, c_reg;
    logic                   last_reg;

    logic                   area_done, tab_done;
    sasi_pkg::entry_t       area_res;
    sasi_pkg::ins_req_t     req;
    sasi_pkg::out_item_t    item;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg  <= sasi_pkg::kind_t'(s_tuser);
                        a_reg     <= s_tdata[SIDE_BITS-1:0];
                        b_reg     <= s_tdata[2*SIDE_BITS-1:SIDE_BITS];
                        c_reg     <= s_tdata[3*SIDE_BITS-1:2*SIDE_BITS];
                        last_reg  <= s_tlast;
                        state_reg <= S_START;
                    end
                end
                S_START: state_reg <= S_AREA;
                S_AREA: begin
                    if (area_done) begin
                        state_reg <= S_TAB;
                    end
                end
                S_TAB: begin
                    if (tab_done) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    sasi_area #(
        .SIDE_BITS (SIDE_BITS)
    ) u_area (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_START),
        .kind_in (kind_reg),
        .side_a  (a_reg),
        .side_b  (b_reg),
        .side_c  (c_reg),
        .done    (area_done),
        .res     (area_res)
    );

    assign req.start = (state_reg == S_AREA) && area_done;
    assign req.last  = last_reg;
    assign req.entry = area_res;

    sasi_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .done      (tab_done),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (item)
    );

    assign m_tdata = sasi_pkg::M_DATA_W'(item.entry.area);
    assign m_tuser = {item.dropped, item.entry.bad, item.entry.kind};
    assign m_tlast = item.run_end;

endmodule
